### rtl/core/bple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bple_pkg
// Shared widths, codes and the cell command type of the positional list engine.
// ----------------------------------------------------------------------------
package bple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int OP_W         = 4;
  localparam int ST_W         = 3;
  // Index and count width: holds counts up to 127, which bounds the capacity.
  localparam int IDX_W        = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_END   = 4'd1,
    OP_INS_AFTER = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_END   = 4'd4,
    OP_DEL_POS   = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_FWD       = 4'd7,
    OP_REV       = 4'd8
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_BEYOND   = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROTL,
    CELL_ROTR
  } cell_op_t;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    cell_op_t           kind;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   cnt;
    logic [IDX_W-1:0]   sel;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

### rtl/core/bple_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bple_req_if
// Request channel: opcode, value and position with valid/ready.
// ----------------------------------------------------------------------------
interface bple_req_if;
  logic                              valid;
  logic                              ready;
  logic [bple_pkg::OP_W-1:0]         opcode;
  logic signed [bple_pkg::DATA_W-1:0] value;
  logic [bple_pkg::POS_W-1:0]        position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

### rtl/core/bple_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bple_rsp_if
// Response channel: status, data, search position and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface bple_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [bple_pkg::ST_W-1:0]          status;
  logic signed [bple_pkg::DATA_W-1:0] data_out;
  logic [bple_pkg::IDX_W-1:0]         found_position;
  logic                               last;

  modport source (output valid, output status, output data_out, output found_position,
                  output last, input ready);
  modport sink   (input valid, input status, input data_out, input found_position,
                  input last, output ready);
endinterface

### rtl/core/bple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bple_cell
// One list slot: holds a word and shifts or rotates with its neighbors.
// ----------------------------------------------------------------------------
module bple_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  bple_pkg::cell_cmd_t           cmd,
  input  logic [bple_pkg::DATA_W-1:0]   left,
  input  logic [bple_pkg::DATA_W-1:0]   right,
  input  logic [bple_pkg::DATA_W-1:0]   head,
  input  logic [bple_pkg::DATA_W-1:0]   tail,
  output logic [bple_pkg::DATA_W-1:0]   data,
  output logic [bple_pkg::DATA_W-1:0]   tap
);

  localparam logic [bple_pkg::IDX_W-1:0] ME = bple_pkg::IDX_W'(INDEX);

  logic is_tail;

  assign is_tail = (ME + bple_pkg::IDX_W'(1)) == cmd.cnt;
  assign tap     = (cmd.sel == ME) ? data : '0;

  always_ff @(posedge clk) begin
    case (cmd.kind)
      bple_pkg::CELL_INS: begin
        // open a gap at idx, everything behind moves back one slot
        if (ME > cmd.idx) begin
          data <= left;
        end else if (ME == cmd.idx) begin
          data <= cmd.value;
        end
      end
      bple_pkg::CELL_DEL: begin
        if (ME >= cmd.idx) begin
          data <= right;
        end
      end
      bple_pkg::CELL_ROTL: begin
        // wrap the head word around to the tail slot
        if (is_tail) begin
          data <= head;
        end else if (ME < cmd.cnt) begin
          data <= right;
        end
      end
      bple_pkg::CELL_ROTR: begin
        if (ME == '0) begin
          data <= tail;
        end else if (ME < cmd.cnt) begin
          data <= left;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/bounded_positional_list_engine_top.sv
`timescale 1ns / 1ps
// Insert and delete results load the output register at the request transfer.
// Search walks the list by rotating the cell chain, then S_SRES loads the result.
// Traversal emits one element per cycle while the output register can take it,
// set by the one-word-per-cycle rotation of the chain; the next request is taken
// once the final result has left the output register.
// Reset clears count, controller and output valid, holds off requests; words undefined.
// ----------------------------------------------------------------------------
// bounded_positional_list_engine_top
// Ordered list of signed words in a shifting chain of cells with a control FSM.
// ----------------------------------------------------------------------------
module bounded_positional_list_engine_top #(
  parameter int CAPACITY = bple_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bple_req_if.sink    req,
  bple_rsp_if.source  rsp
);

  localparam int IW = bple_pkg::IDX_W;
  localparam int DW = bple_pkg::DATA_W;
  localparam logic [IW-1:0] CAP_N = IW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SRES
  } state_t;

  state_t                state, state_next;
  logic [IW-1:0]         cnt, cnt_next;
  logic [IW-1:0]         step, step_next;
  bple_pkg::opcode_t     wop, wop_next;
  logic [DW-1:0]         key, key_next;
  logic                  found, found_next;
  logic [IW-1:0]         fpos, fpos_next;

  logic                  o_valid;
  bple_pkg::status_t     o_status;
  logic [DW-1:0]         o_data;
  logic [IW-1:0]         o_fpos;
  logic                  o_last;

  logic                  load_out;
  bple_pkg::status_t     n_status;
  logic [DW-1:0]         n_data;
  logic [IW-1:0]         n_fpos;
  logic                  n_last;

  logic                  out_free;
  logic                  accept;
  logic                  step_last;
  bple_pkg::cell_cmd_t   cmd;
  logic [DW-1:0]         cell_data [CAPACITY];
  logic [DW-1:0]         cell_tap  [CAPACITY];
  logic [DW-1:0]         bus;

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    bple_cell #(.INDEX(g)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (left_w),
      .right (right_w),
      .head  (cell_data[0]),
      .tail  (bus),
      .data  (cell_data[g]),
      .tap   (cell_tap[g])
    );
  end

  // Only the selected cell drives a nonzero tap.
  always_comb begin
    bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bus = bus | cell_tap[i];
    end
  end

  // ---------------- control ----------------
  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = !rst && (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign step_last = (step + IW'(1)) == cnt;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    wop_next   = wop;
    key_next   = key;
    found_next = found;
    fpos_next  = fpos;
    load_out   = 1'b0;
    n_status   = bple_pkg::ST_OK;
    n_data     = '0;
    n_fpos     = '0;
    n_last     = 1'b1;
    cmd.kind   = bple_pkg::CELL_HOLD;
    cmd.idx    = '0;
    cmd.cnt    = cnt;
    cmd.sel    = '0;
    cmd.value  = req.value;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.opcode) inside
            bple_pkg::OP_INS_FRONT, bple_pkg::OP_INS_END, bple_pkg::OP_INS_AFTER: begin
              load_out = 1'b1;
              if (cnt >= CAP_N) begin
                n_status = bple_pkg::ST_FULL;
              end else begin
                cmd.kind = bple_pkg::CELL_INS;
                if (req.opcode == bple_pkg::OP_INS_FRONT ||
                    (req.opcode == bple_pkg::OP_INS_AFTER &&
                     (req.position == '0 || cnt == '0))) begin
                  cmd.idx = '0;
                end else if (req.opcode == bple_pkg::OP_INS_END ||
                             req.position >= bple_pkg::POS_W'(cnt)) begin
                  cmd.idx = cnt;
                end else begin
                  cmd.idx = IW'(req.position);
                end
                cnt_next = cnt + IW'(1);
                n_data   = req.value;
              end
            end
            bple_pkg::OP_DEL_FRONT, bple_pkg::OP_DEL_END, bple_pkg::OP_DEL_POS: begin
              load_out = 1'b1;
              if (cnt == '0) begin
                n_status = bple_pkg::ST_EMPTY;
              end else if (req.opcode == bple_pkg::OP_DEL_POS && req.position == '0) begin
                n_status = bple_pkg::ST_BADPOS;
              end else if (req.opcode == bple_pkg::OP_DEL_POS &&
                           req.position > bple_pkg::POS_W'(cnt)) begin
                n_status = bple_pkg::ST_BEYOND;
              end else begin
                cmd.kind = bple_pkg::CELL_DEL;
                if (req.opcode == bple_pkg::OP_DEL_FRONT) begin
                  cmd.idx = '0;
                end else if (req.opcode == bple_pkg::OP_DEL_END) begin
                  cmd.idx = cnt - IW'(1);
                end else begin
                  cmd.idx = IW'(req.position - bple_pkg::POS_W'(1));
                end
                cmd.sel  = cmd.idx;
                n_data   = bus;
                cnt_next = cnt - IW'(1);
              end
            end
            bple_pkg::OP_SEARCH, bple_pkg::OP_FWD, bple_pkg::OP_REV: begin
              if (cnt == '0) begin
                load_out = 1'b1;
                n_status = bple_pkg::ST_EMPTY;
                if (req.opcode == bple_pkg::OP_SEARCH) begin
                  n_data = req.value;
                end
              end else begin
                state_next = S_WALK;
                wop_next   = bple_pkg::opcode_t'(req.opcode);
                key_next   = req.value;
                step_next  = '0;
                found_next = 1'b0;
                fpos_next  = '0;
              end
            end
            default: begin
              // unused opcode: drop without a result
            end
          endcase
        end
      end
      S_WALK: begin
        if (wop == bple_pkg::OP_SEARCH) begin
          cmd.kind  = bple_pkg::CELL_ROTL;
          step_next = step + IW'(1);
          if (!found && cell_data[0] == key) begin
            found_next = 1'b1;
            fpos_next  = step + IW'(1);
          end
          if (step_last) begin
            state_next = S_SRES;
          end
        end else if (out_free) begin
          load_out  = 1'b1;
          n_last    = step_last;
          step_next = step + IW'(1);
          if (wop == bple_pkg::OP_FWD) begin
            cmd.kind = bple_pkg::CELL_ROTL;
            n_data   = cell_data[0];
          end else begin
            cmd.kind = bple_pkg::CELL_ROTR;
            cmd.sel  = cnt - IW'(1);
            n_data   = bus;
          end
          if (step_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SRES: begin
        if (out_free) begin
          load_out   = 1'b1;
          n_data     = key;
          state_next = S_IDLE;
          if (found) begin
            n_fpos = fpos;
          end else begin
            n_status = bple_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      step    <= '0;
      found   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
      found <= found_next;
      if (load_out) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
    wop  <= wop_next;
    key  <= key_next;
    fpos <= fpos_next;
    if (load_out) begin
      o_status <= n_status;
      o_data   <= n_data;
      o_fpos   <= n_fpos;
      o_last   <= n_last;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.status         = o_status;
  assign rsp.data_out       = o_data;
  assign rsp.found_position = o_fpos;
  assign rsp.last           = o_last;

endmodule

### rtl/core/bple_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bple_chk
// Port-level checks on the response channel of the list engine.
// ----------------------------------------------------------------------------
module bple_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [bple_pkg::ST_W-1:0]      status,
  input logic [bple_pkg::DATA_W-1:0]    data_out,
  input logic [bple_pkg::IDX_W-1:0]     found_position,
  input logic                           last
);

  // A stalled response holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(data_out) &&
                                $stable(found_position) && $stable(last))
    else $error("response changed while stalled");

  // No request transfer during reset, and no response right after it.
  a_reset: assert property (@(posedge clk)
    rst |-> !(req_valid && req_ready) ##1 !rsp_valid)
    else $error("channel active during or right after reset");

  // Only traversal gives more than one result, each one ok.
  a_mid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> status == bple_pkg::ST_OK && found_position == '0)
    else $error("non-final result that is not a traversal element");

  a_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found_position != '0 |-> status == bple_pkg::ST_OK && last)
    else $error("search position on a result that is not a hit");

  // No new request is taken while a traversal is still emitting.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> !req_ready)
    else $error("request taken during a traversal");

endmodule

bind bounded_positional_list_engine_top bple_chk u_bple_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .status         (rsp.status),
  .data_out       (rsp.data_out),
  .found_position (rsp.found_position),
  .last           (rsp.last)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded positional list engine. Requests come
// from a pending queue that is filled at time zero: a directed pass over the
// corner cases, then insert-heavy, delete-heavy and mixed random phases. A
// shadow list predicts every response at the request transfer. Responses are
// checked in order, field by field, under random sender bursts and receiver
// stalls, including long receiver hold-offs that back the engine up.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIST_CAP     = bple_pkg::CAPACITY_DEF;
  localparam int DW           = bple_pkg::DATA_W;
  localparam int OW           = bple_pkg::OP_W;
  localparam int PW           = bple_pkg::POS_W;
  localparam int XW           = bple_pkg::IDX_W;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 4 * LIST_CAP + 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    logic [OW-1:0]        opcode;
    logic signed [DW-1:0] value;
    logic [PW-1:0]        position;
  } list_req_t;

  typedef struct {
    bple_pkg::status_t    status;
    logic signed [DW-1:0] data;
    logic [XW-1:0]        fpos;
    logic                 last;
  } list_rsp_t;

  logic clk;
  logic rst;

  bple_req_if req_bus ();
  bple_rsp_if rsp_bus ();

  bounded_positional_list_engine_top #(
    .CAPACITY (LIST_CAP)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow list and bookkeeping
  logic signed [DW-1:0] shadow_words [LIST_CAP];
  int unsigned          shadow_len;
  list_req_t            req_queue [$];
  list_rsp_t            rsp_queue [$];
  logic signed [DW-1:0] key_pool [$];

  int unsigned err_cnt      = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned full_cnt     = 0;
  int unsigned empty_cnt    = 0;
  int unsigned hit_cnt      = 0;
  int unsigned miss_cnt     = 0;
  logic        req_took;

  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_idx   = 0;
  int unsigned hold_at [2] = '{120, 330};
  int unsigned mode_left  = 0;
  int unsigned stall_mode = 0;
  logic [7:0]  stall_pat  = 8'hFF;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH @%0t %s: got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_rsp(bple_pkg::status_t st, logic signed [DW-1:0] data,
                          logic [XW-1:0] fpos, logic lst);
    list_rsp_t r;
    r.status = st;
    r.data   = data;
    r.fpos   = fpos;
    r.last   = lst;
    rsp_queue.push_back(r);
    if (st == bple_pkg::ST_FULL)
      full_cnt++;
    if (st == bple_pkg::ST_EMPTY)
      empty_cnt++;
  endtask

  // Apply one request to the shadow list and queue the responses it causes.
  task automatic predict_list_op(logic [OW-1:0] op_bits, logic signed [DW-1:0] val,
                                 logic [PW-1:0] pos);
    bple_pkg::opcode_t    op;
    int unsigned          idx;
    int unsigned          i;
    int                   hit;
    logic signed [DW-1:0] w;
    op = bple_pkg::opcode_t'(op_bits);
    case (op)
      bple_pkg::OP_INS_FRONT, bple_pkg::OP_INS_END, bple_pkg::OP_INS_AFTER: begin
        if (shadow_len >= LIST_CAP) begin
          push_rsp(bple_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          if (op == bple_pkg::OP_INS_FRONT ||
              (op == bple_pkg::OP_INS_AFTER && (pos == 0 || shadow_len == 0)))
            idx = 0;
          else if (op == bple_pkg::OP_INS_END || pos >= shadow_len)
            idx = shadow_len;
          else
            idx = pos;
          for (i = shadow_len; i > idx; i--)
            shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = val;
          shadow_len++;
          push_rsp(bple_pkg::ST_OK, val, '0, 1'b1);
        end
      end
      bple_pkg::OP_DEL_FRONT, bple_pkg::OP_DEL_END, bple_pkg::OP_DEL_POS: begin
        if (shadow_len == 0) begin
          push_rsp(bple_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else if (op == bple_pkg::OP_DEL_POS && pos == 0) begin
          push_rsp(bple_pkg::ST_BADPOS, '0, '0, 1'b1);
        end else if (op == bple_pkg::OP_DEL_POS && pos > shadow_len) begin
          push_rsp(bple_pkg::ST_BEYOND, '0, '0, 1'b1);
        end else begin
          if (op == bple_pkg::OP_DEL_FRONT)
            idx = 0;
          else if (op == bple_pkg::OP_DEL_END)
            idx = shadow_len - 1;
          else
            idx = pos - 1;
          w = shadow_words[idx];
          for (i = idx; i + 1 < shadow_len; i++)
            shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          push_rsp(bple_pkg::ST_OK, w, '0, 1'b1);
        end
      end
      bple_pkg::OP_SEARCH: begin
        if (shadow_len == 0) begin
          push_rsp(bple_pkg::ST_EMPTY, val, '0, 1'b1);
        end else begin
          hit = -1;
          for (i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_words[i] == val)
              hit = i;
          if (hit >= 0) begin
            push_rsp(bple_pkg::ST_OK, val, XW'(hit + 1), 1'b1);
            hit_cnt++;
          end else begin
            push_rsp(bple_pkg::ST_NOTFOUND, val, '0, 1'b1);
            miss_cnt++;
          end
        end
      end
      bple_pkg::OP_FWD, bple_pkg::OP_REV: begin
        if (shadow_len == 0) begin
          push_rsp(bple_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            idx = (op == bple_pkg::OP_FWD) ? i : shadow_len - 1 - i;
            push_rsp(bple_pkg::ST_OK, shadow_words[idx], '0, (i + 1 == shadow_len));
          end
        end
      end
      default: begin
        // unused opcode: no response, list unchanged
      end
    endcase
  endtask

  task automatic add_req(logic [OW-1:0] op, logic signed [DW-1:0] val,
                         logic [PW-1:0] pos);
    list_req_t r;
    r.opcode   = op;
    r.value    = val;
    r.position = pos;
    req_queue.push_back(r);
  endtask

  function automatic logic signed [DW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return int'($urandom_range(0, 8)) - 4;
    else if (r == 3)
      return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else
      return $urandom;
  endfunction

  function automatic logic [PW-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return PW'($urandom_range(0, LIST_CAP + 2));
    else if (r < 8)
      return PW'($urandom_range(0, 4));
    else
      return PW'($urandom_range(0, 255));
  endfunction

  task automatic gen_random_phase(int unsigned n, int unsigned ins_pct, int unsigned del_pct);
    int unsigned          done;
    int unsigned          r;
    logic [OW-1:0]        op;
    logic signed [DW-1:0] w;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // ignored by the engine, so not counted
        add_req(OW'($urandom_range(9, 15)), $urandom, PW'($urandom_range(0, 255)));
      end else begin
        if (r < 3 + ins_pct) begin
          case ($urandom_range(0, 2))
            0:       op = bple_pkg::OP_INS_FRONT;
            1:       op = bple_pkg::OP_INS_END;
            default: op = bple_pkg::OP_INS_AFTER;
          endcase
          w = pick_word();
          key_pool.push_back(w);
          if (key_pool.size() > 24)
            void'(key_pool.pop_front());
        end else if (r < 3 + ins_pct + del_pct) begin
          case ($urandom_range(0, 3))
            0:       op = bple_pkg::OP_DEL_FRONT;
            1:       op = bple_pkg::OP_DEL_END;
            default: op = bple_pkg::OP_DEL_POS;
          endcase
          w = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0:       op = bple_pkg::OP_FWD;
            1:       op = bple_pkg::OP_REV;
            default: op = bple_pkg::OP_SEARCH;
          endcase
          w = $urandom;
          if (op == bple_pkg::OP_SEARCH && key_pool.size() != 0 && $urandom_range(0, 9) < 6)
            w = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        add_req(op, w, pick_pos());
        done++;
      end
    end
  endtask

  // Sender: hold each item until its transfer, then advance in bursts.
  always @(negedge clk) begin : req_driver
    list_req_t nxt;
    if (!rst && (!req_bus.valid || req_took)) begin
      if (req_took)
        void'(req_queue.pop_front());
      if (gap_left != 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        nxt = req_queue[0];
        req_bus.valid    <= 1'b1;
        req_bus.opcode   <= nxt.opcode;
        req_bus.value    <= nxt.value;
        req_bus.position <= nxt.position;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall patterns, plus long hold-offs at set request counts.
  always @(negedge clk) begin : rsp_receiver
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_idx < 2 && accepted_cnt >= hold_at[hold_idx]) begin
        hold_idx++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
          stall_pat  = 8'($urandom) | 8'h01;
        end
        mode_left--;
        case (stall_mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 4) != 0);
          default: begin
            rsp_bus.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
          end
        endcase
      end
    end
  end

  // Predict at the request transfer, check each response transfer.
  always @(posedge clk) begin : rsp_monitor
    list_rsp_t want;
    if (rst) begin
      req_took <= 1'b0;
    end else begin
      req_took <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        accepted_cnt++;
        predict_list_op(req_bus.opcode, req_bus.value, req_bus.position);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (rsp_queue.size() == 0) begin
          flag_mismatch("response with nothing pending", rsp_bus.data_out, '0);
        end else begin
          want = rsp_queue.pop_front();
          checked_cnt++;
          if (rsp_bus.status !== want.status)
            flag_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
          if (rsp_bus.data_out !== want.data)
            flag_mismatch("data_out", rsp_bus.data_out, want.data);
          if (rsp_bus.found_position !== want.fpos)
            flag_mismatch("found_position", 32'(rsp_bus.found_position), 32'(want.fpos));
          if (rsp_bus.last !== want.last)
            flag_mismatch("last", 32'(rsp_bus.last), 32'(want.last));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    int unsigned ph;
    rst              = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.opcode   = '0;
    req_bus.value    = '0;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    shadow_len       = 0;

    // Empty list: traversals, deletes and search
    add_req(bple_pkg::OP_FWD, $urandom, PW'($urandom_range(0, 255)));
    add_req(bple_pkg::OP_REV, $urandom, PW'($urandom_range(0, 255)));
    add_req(bple_pkg::OP_DEL_FRONT, $urandom, 8'd0);
    add_req(bple_pkg::OP_DEL_END, $urandom, 8'd255);
    add_req(bple_pkg::OP_DEL_POS, $urandom, 8'd3);
    add_req(bple_pkg::OP_SEARCH, 32'sh1234_5678, 8'd0);
    // Insert-after on an empty list goes to the front
    add_req(bple_pkg::OP_INS_AFTER, 32'sh7FFF_FFFF, 8'd7);
    add_req(bple_pkg::OP_INS_FRONT, 32'sh8000_0000, 8'd0);
    add_req(bple_pkg::OP_INS_END, -32'sd1, 8'd255);
    add_req(bple_pkg::OP_INS_AFTER, 32'sd0, 8'd0);
    add_req(bple_pkg::OP_INS_AFTER, 32'sh5A5A_5A5A, 8'd2);
    add_req(bple_pkg::OP_INS_AFTER, 32'sd1, 8'd255);
    // Fill to capacity, with a duplicate of the most negative word
    for (k = 2; k < 12; k++)
      add_req(bple_pkg::OP_INS_END, (k == 5) ? 32'sh8000_0000 : 32'(k) * 32'h0101_0101,
              8'($urandom));
    add_req(bple_pkg::OP_INS_FRONT, 32'sd5, 8'd0);
    add_req(bple_pkg::OP_INS_END, 32'sd6, 8'd0);
    add_req(bple_pkg::OP_INS_AFTER, 32'sd7, 8'd3);
    add_req(bple_pkg::OP_SEARCH, 32'sh8000_0000, 8'd0);
    add_req(bple_pkg::OP_SEARCH, 32'shDEAD_BEEF, 8'd0);
    add_req(bple_pkg::OP_FWD, $urandom, 8'd0);
    add_req(bple_pkg::OP_REV, $urandom, 8'd0);
    add_req(bple_pkg::OP_DEL_POS, $urandom, 8'd0);
    add_req(bple_pkg::OP_DEL_POS, $urandom, 8'd255);
    add_req(bple_pkg::OP_DEL_POS, $urandom, 8'd17);
    add_req(bple_pkg::OP_DEL_POS, $urandom, 8'd3);
    add_req(bple_pkg::OP_DEL_FRONT, $urandom, 8'd0);
    add_req(bple_pkg::OP_DEL_END, $urandom, 8'd0);
    add_req(OW'(4'hF), $urandom, PW'($urandom_range(0, 255)));

    for (ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++) begin
      case (ph % 3)
        0:       gen_random_phase(PHASE_ITEMS, 65, 15);
        1:       gen_random_phase(PHASE_ITEMS, 15, 65);
        default: gen_random_phase(PHASE_ITEMS, 35, 35);
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_queue.size() != 0 || rsp_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (rsp_queue.size() != 0)
      flag_mismatch("responses never delivered", 32'(rsp_queue.size()), '0);

    $display("Run covered %0d requests and %0d checked responses", accepted_cnt, checked_cnt);
    $display("Full %0d, empty %0d, search hits %0d, misses %0d",
             full_cnt, empty_cnt, hit_cnt, miss_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d responses pending", rsp_queue.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
